// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, opcode and status codes,
// and the structs passed between the queue modules. No dependencies.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = 8;
    localparam int KW = 32;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_PEEK     = 3'd2,
        OP_LIST_ALL = 3'd3,
        OP_LIST_EQ  = 3'd4,
        OP_LIST_LE  = 3'd5,
        OP_CLEAR    = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_ENTRY     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef struct packed {
        logic p_eq;
        logic p_le;
        logic k_eq;
    } t_cmp;

    typedef struct packed {
        logic          en;
        logic [IW-1:0] addr;
        logic [PW-1:0] prio;
        logic [KW-1:0] key;
    } t_wr;

    typedef struct packed {
        t_status       status;
        logic [PW-1:0] prio;
        logic [KW-1:0] key;
        logic          last;
    } t_res;

    function automatic t_res mk_res(t_status st, logic [PW-1:0] p, logic [KW-1:0] k,
                                    logic l);
        t_res r;
        r.status = st;
        r.prio   = p;
        r.key    = k;
        r.last   = l;
        return r;
    endfunction

endpackage

// ===== rtl/core/spq_store.sv =====
// Entry storage of the queue: priority and key arrays with one write port
// and one registered read port. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_store import spq_pkg::*; (
    input  logic          i_clk,
    input  t_wr           i_wr,
    input  logic [IW-1:0] i_rd_addr,
    output logic [PW-1:0] o_rd_prio,
    output logic [KW-1:0] o_rd_key
);

    logic [PW-1:0] mem_prio [CAPACITY];
    logic [KW-1:0] mem_key  [CAPACITY];
    logic [PW-1:0] r_rd_prio;
    logic [KW-1:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_prio[i_wr.addr] <= i_wr.prio;
            mem_key[i_wr.addr]  <= i_wr.key;
        end
        r_rd_prio <= mem_prio[i_rd_addr];
        r_rd_key  <= mem_key[i_rd_addr];
    end

    assign o_rd_prio = r_rd_prio;
    assign o_rd_key  = r_rd_key;

endmodule

// ===== rtl/core/spq_cmp.sv =====
// Shared compare unit: checks one stored entry against the request priority
// and key. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_cmp import spq_pkg::*; (
    input  logic [PW-1:0] i_ent_prio,
    input  logic [KW-1:0] i_ent_key,
    input  logic [PW-1:0] i_req_prio,
    input  logic [KW-1:0] i_req_key,
    output t_cmp          o_cmp
);

    always_comb begin
        o_cmp.p_eq = (i_ent_prio == i_req_prio);
        o_cmp.p_le = (i_ent_prio <= i_req_prio);
        o_cmp.k_eq = (i_ent_key == i_req_key);
    end

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// Sequencer of the queue: walks the stored entries one at a time through the
// store and the compare unit, and registers each result word. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_opcode,
    input  logic [PW-1:0] i_priority_req,
    input  logic [KW-1:0] i_entry_key,
    input  logic [PW-1:0] i_rd_prio,
    input  logic [KW-1:0] i_rd_key,
    input  t_cmp          i_cmp,
    output logic [PW-1:0] o_req_prio,
    output logic [KW-1:0] o_req_key,
    output logic [IW-1:0] o_rd_addr,
    output t_wr           o_wr,
    output logic          o_busy,
    output logic          o_strobe,
    output t_res          o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EV, S_PUT, S_SH_RD, S_SH_EV, S_FLUSH
    } t_state;

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [PW-1:0] r_pr, n_pr;
    logic [KW-1:0] r_key, n_key;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_have, n_have;
    logic [PW-1:0] r_pend_prio, n_pend_prio;
    logic [KW-1:0] r_pend_key, n_pend_key;
    logic          r_valid, n_valid;
    t_res          r_res, n_res;

    logic          w_last_idx;
    logic          w_shift_end;
    logic          w_hit;
    logic [CW-1:0] w_addr;

    assign w_last_idx  = (({1'b0, r_idx} + (CW+1)'(1)) == {1'b0, r_cnt});
    assign w_shift_end = (({1'b0, r_idx} + (CW+1)'(2)) >= {1'b0, r_cnt});
    assign w_hit = (r_op == OP_LIST_ALL) || ((r_op == OP_LIST_EQ) && i_cmp.p_eq)
                   || ((r_op == OP_LIST_LE) && i_cmp.p_le);

    always_comb begin
        case (r_state)
            S_SH_RD: w_addr = r_idx + CW'(1);
            S_RD:    w_addr = (r_op == OP_INSERT) ? (r_idx - CW'(1)) : r_idx;
            default: w_addr = r_idx;
        endcase
    end

    assign o_rd_addr = w_addr[IW-1:0];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pr        = r_pr;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_have      = r_have;
        n_pend_prio = r_pend_prio;
        n_pend_key  = r_pend_key;
        n_valid     = 1'b0;
        n_res       = r_res;
        o_wr.en     = 1'b0;
        o_wr.addr   = r_idx[IW-1:0];
        o_wr.prio   = r_pr;
        o_wr.key    = r_key;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op   = t_op'(i_opcode);
                    n_pr   = i_priority_req;
                    n_key  = i_entry_key;
                    n_idx  = '0;
                    n_have = 1'b0;
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (r_cnt == CAP_C) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(ST_FULL, '0, '0, 1'b1);
                            end else if (r_cnt == '0) begin
                                o_wr.en   = 1'b1;
                                o_wr.addr = '0;
                                o_wr.prio = i_priority_req;
                                o_wr.key  = i_entry_key;
                                n_cnt     = r_cnt + CW'(1);
                                n_valid   = 1'b1;
                                n_res     = mk_res(ST_INSERTED, '0, '0, 1'b1);
                            end else begin
                                n_idx   = r_cnt;
                                n_state = S_RD;
                            end
                        end
                        OP_DELETE, OP_PEEK, OP_LIST_ALL: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(ST_EMPTY, '0, '0, 1'b1);
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_LIST_EQ, OP_LIST_LE: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_valid = 1'b1;
                            n_res   = mk_res(ST_CLEARED, '0, '0, 1'b1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                case (r_op)
                    OP_INSERT: begin
                        o_wr.en = 1'b1;
                        if (!i_cmp.p_le) begin
                            o_wr.prio = i_rd_prio;
                            o_wr.key  = i_rd_key;
                            n_idx     = r_idx - CW'(1);
                            n_state   = (r_idx == CW'(1)) ? S_PUT : S_RD;
                        end else begin
                            n_cnt   = r_cnt + CW'(1);
                            n_valid = 1'b1;
                            n_res   = mk_res(ST_INSERTED, '0, '0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                    OP_DELETE: begin
                        if (i_cmp.p_eq && i_cmp.k_eq) begin
                            n_valid = 1'b1;
                            n_res   = mk_res(ST_REMOVED, r_pr, r_key, 1'b1);
                            if (w_last_idx) begin
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_SH_RD;
                            end
                        end else if (w_last_idx) begin
                            n_valid = 1'b1;
                            n_res   = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_RD;
                        end
                    end
                    OP_PEEK: begin
                        n_valid = 1'b1;
                        n_res   = mk_res(ST_ENTRY, i_rd_prio, i_rd_key, 1'b1);
                        n_state = S_IDLE;
                    end
                    default: begin
                        if (w_hit) begin
                            if (r_have) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(ST_ENTRY, r_pend_prio, r_pend_key, 1'b0);
                            end
                            n_pend_prio = i_rd_prio;
                            n_pend_key  = i_rd_key;
                            n_have      = 1'b1;
                        end
                        if (w_last_idx) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_PUT: begin
                o_wr.en = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_valid = 1'b1;
                n_res   = mk_res(ST_INSERTED, '0, '0, 1'b1);
                n_state = S_IDLE;
            end
            S_SH_RD: begin
                n_state = S_SH_EV;
            end
            S_SH_EV: begin
                o_wr.en   = 1'b1;
                o_wr.prio = i_rd_prio;
                o_wr.key  = i_rd_key;
                n_idx     = r_idx + CW'(1);
                if (w_shift_end) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                if (r_have) begin
                    n_res = mk_res(ST_ENTRY, r_pend_prio, r_pend_key, 1'b1);
                end else if (r_op == OP_LIST_ALL) begin
                    n_res = mk_res(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    n_res = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_pr        <= n_pr;
            r_key       <= n_key;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_have      <= n_have;
            r_pend_prio <= n_pend_prio;
            r_pend_key  <= n_pend_key;
            r_valid     <= n_valid;
            r_res       <= n_res;
        end
    end

    assign o_req_prio = r_pr;
    assign o_req_key  = r_key;
    assign o_busy     = (r_state != S_IDLE);
    assign o_strobe   = r_valid;
    assign o_res      = r_res;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue: one word in, a walk over the stored entries, one or more words out.
// Insert walks down from the last stored entry, delete and the lists walk up from the first one,
// peek reads only the first; clear, full insert and empty cases answer the next cycle and stay ready.
// The bound is the single read port of the entry store: each entry is read, then evaluated.
// Results appear as one-cycle strobes and cannot be stalled; i_rst_n (synchronous) empties
// the queue and returns the sequencer to idle.
`timescale 1ns / 1ps
module sorted_priority_queue import spq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    i_opcode,
    input  logic [PW-1:0] i_priority_req,
    input  logic [KW-1:0] i_entry_key,
    output logic          o_strobe,
    output logic [2:0]    o_status,
    output logic [PW-1:0] o_out_priority,
    output logic [KW-1:0] o_out_key,
    output logic          o_last
);

    logic [PW-1:0] w_rd_prio;
    logic [KW-1:0] w_rd_key;
    logic [PW-1:0] w_req_prio;
    logic [KW-1:0] w_req_key;
    logic [IW-1:0] w_rd_addr;
    t_wr           w_wr;
    t_cmp          w_cmp;
    t_res          w_res;

    spq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_prio (w_rd_prio),
        .o_rd_key  (w_rd_key)
    );

    spq_cmp u_cmp (
        .i_ent_prio (w_rd_prio),
        .i_ent_key  (w_rd_key),
        .i_req_prio (w_req_prio),
        .i_req_key  (w_req_key),
        .o_cmp      (w_cmp)
    );

    spq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_entry_key    (i_entry_key),
        .i_rd_prio      (w_rd_prio),
        .i_rd_key       (w_rd_key),
        .i_cmp          (w_cmp),
        .o_req_prio     (w_req_prio),
        .o_req_key      (w_req_key),
        .o_rd_addr      (w_rd_addr),
        .o_wr           (w_wr),
        .o_busy         (busy),
        .o_strobe       (o_strobe),
        .o_res          (w_res)
    );

    assign o_status       = w_res.status;
    assign o_out_priority = w_res.prio;
    assign o_out_key      = w_res.key;
    assign o_last         = w_res.last;

endmodule

// ===== rtl/core/spq_chk.sv =====
// Port checker for the sorted priority queue and its bind to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps
module spq_chk import spq_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic [2:0]    i_opcode,
    input logic          o_strobe,
    input logic [2:0]    o_status,
    input logic [PW-1:0] o_out_priority,
    input logic [KW-1:0] o_out_key,
    input logic          o_last
);

    // A word that is not the final one can only come while a list walk is running.
    a_mid_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final word while idle");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_ENTRY) |-> o_last)
        else $error("status word without last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_ENTRY) && (o_status != ST_REMOVED)
        |-> (o_out_priority == '0) && (o_out_key == '0))
        else $error("status word with nonzero payload");

    a_clear_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_CLEAR)
        |=> o_strobe && (o_status == ST_CLEARED) && o_last && !busy)
        else $error("clear not answered in one cycle");

    a_unused_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == 3'd7) |=> !o_strobe && !busy)
        else $error("unused opcode produced activity");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_out_priority (o_out_priority),
    .o_out_key      (o_out_key),
    .o_last         (o_last)
);

// ===== bench/spq_checker.sv =====
// Checker for the sorted priority queue: watches the command and result channels,
// keeps its own copy of the queue contents and compares every result word in order.
// Depends on spq_pkg for sizes, opcode and status codes and the result struct.
`timescale 1ns / 1ps
module spq_checker import spq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  logic [2:0]    i_opcode,
    input  logic [PW-1:0] i_priority_req,
    input  logic [KW-1:0] i_entry_key,
    input  logic          i_strobe,
    input  logic [2:0]    i_status,
    input  logic [PW-1:0] i_out_priority,
    input  logic [KW-1:0] i_out_key,
    input  logic          i_last,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);

    logic [PW-1:0] held_prio [CAPACITY];
    logic [KW-1:0] held_key [CAPACITY];
    int            held_count = 0;
    t_res          expected_words [$];
    int            fail_count = 0;
    int            checked_words = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic push_expected(input t_status st, input logic [PW-1:0] p,
                                 input logic [KW-1:0] k, input logic l);
        t_res w;
        w.status = st;
        w.prio   = p;
        w.key    = k;
        w.last   = l;
        expected_words.push_back(w);
    endtask

    function automatic logic list_hit(input logic [2:0] op, input logic [PW-1:0] entry_p,
                                      input logic [PW-1:0] query_p);
        return (op == OP_LIST_ALL) || (op == OP_LIST_EQ && entry_p == query_p) ||
               (op == OP_LIST_LE && entry_p <= query_p);
    endfunction

    task automatic apply_command(input logic [2:0] op, input logic [PW-1:0] p,
                                 input logic [KW-1:0] k);
        int pos;
        int hits;
        int emitted;
        case (op)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    push_expected(ST_FULL, '0, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= p) pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_prio[i] = held_prio[i-1];
                        held_key[i]  = held_key[i-1];
                    end
                    held_prio[pos] = p;
                    held_key[pos]  = k;
                    held_count++;
                    push_expected(ST_INSERTED, '0, '0, 1'b1);
                end
            end
            OP_DELETE: begin
                if (held_count == 0) begin
                    push_expected(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < held_count && !(held_prio[pos] == p && held_key[pos] == k))
                        pos++;
                    if (pos == held_count) begin
                        push_expected(ST_NOT_FOUND, '0, '0, 1'b1);
                    end else begin
                        push_expected(ST_REMOVED, p, k, 1'b1);
                        for (int j = pos; j + 1 < held_count; j++) begin
                            held_prio[j] = held_prio[j+1];
                            held_key[j]  = held_key[j+1];
                        end
                        held_count--;
                    end
                end
            end
            OP_PEEK: begin
                if (held_count == 0) begin
                    push_expected(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    push_expected(ST_ENTRY, held_prio[0], held_key[0], 1'b1);
                end
            end
            OP_LIST_ALL, OP_LIST_EQ, OP_LIST_LE: begin
                hits = 0;
                for (int i = 0; i < held_count; i++)
                    if (list_hit(op, held_prio[i], p)) hits++;
                if (hits == 0) begin
                    push_expected((op == OP_LIST_ALL) ? ST_EMPTY : ST_NOT_FOUND, '0, '0, 1'b1);
                end else begin
                    emitted = 0;
                    for (int i = 0; i < held_count; i++) begin
                        if (list_hit(op, held_prio[i], p)) begin
                            emitted++;
                            push_expected(ST_ENTRY, held_prio[i], held_key[i],
                                          emitted == hits);
                        end
                    end
                end
            end
            OP_CLEAR: begin
                held_count = 0;
                push_expected(ST_CLEARED, '0, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_word(input logic [2:0] st, input logic [PW-1:0] p,
                              input logic [KW-1:0] k, input logic l);
        t_res want;
        checked_words++;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word: status %0d prio %0d key %h last %0d",
                                      st, p, k, l));
            return;
        end
        want = expected_words.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        if (p !== want.prio)
            report_mismatch($sformatf("priority %0d, expected %0d", p, want.prio));
        if (k !== want.key)
            report_mismatch($sformatf("key %h, expected %h", k, want.key));
        if (l !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", l, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            expected_words.delete();
        end else begin
            if (i_strobe) check_word(i_status, i_out_priority, i_out_key, i_last);
            if (i_start && !i_busy) apply_command(i_opcode, i_priority_req, i_entry_key);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_words.size();
        o_checked    <= checked_words;
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the sorted priority queue bench: clock, reset, directed and phased random
// command words, and the verdict. Depends on spq_pkg, sorted_priority_queue and spq_checker.
`timescale 1ns / 1ps
module testbench;
    import spq_pkg::*;

    localparam int          RANDOM_WORDS = 380;
    localparam int          PHASE_WORDS  = 40;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [2:0]  OP_UNUSED    = 3'd7;
    localparam int          MODE_FILL    = 0;
    localparam int          MODE_MIXED   = 1;
    localparam int          MODE_DRAIN   = 2;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [2:0]    i_opcode;
    logic [PW-1:0] i_priority_req;
    logic [KW-1:0] i_entry_key;
    logic          o_strobe;
    logic [2:0]    o_status;
    logic [PW-1:0] o_out_priority;
    logic [KW-1:0] o_out_key;
    logic          o_last;

    int            fail_count;
    int            pending_words;
    int            checked_words;
    int            cycle_count = 0;
    int            counted_words = 0;
    int            directed_words;
    int            phase;
    logic [PW-1:0] pool_prio [$];
    logic [KW-1:0] pool_key [$];

    sorted_priority_queue u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_entry_key    (i_entry_key),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_key      (o_out_key),
        .o_last         (o_last)
    );

    spq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_entry_key    (i_entry_key),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_out_priority (o_out_priority),
        .i_out_key      (o_out_key),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words),
        .o_checked      (checked_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, pending_words);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [PW-1:0] p,
                             input logic [KW-1:0] k, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < 19) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_priority_req <= p;
        i_entry_key    <= k;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (op != OP_UNUSED) counted_words++;
    endtask

    function automatic logic [PW-1:0] rand_prio();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return PW'($urandom_range(255));
            default: return PW'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return KW'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_word(input int mode, input bit may_idle);
        int            roll;
        int            insert_pct;
        int            delete_pct;
        int            pick;
        logic [2:0]    op;
        logic [PW-1:0] p;
        logic [KW-1:0] k;
        insert_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 12 : 35;
        delete_pct = (mode == MODE_FILL) ? 8 : (mode == MODE_DRAIN) ? 50 : 30;
        roll = $urandom_range(99);
        p = rand_prio();
        k = rand_key();
        if (roll < 2) begin
            op = OP_UNUSED;
        end else if (roll < 4) begin
            op = OP_CLEAR;
        end else if (roll < 4 + insert_pct) begin
            op = OP_INSERT;
            pool_prio.push_back(p);
            pool_key.push_back(k);
            if (pool_prio.size() > 48) begin
                void'(pool_prio.pop_front());
                void'(pool_key.pop_front());
            end
        end else if (roll < 4 + insert_pct + delete_pct) begin
            op = OP_DELETE;
            if (pool_prio.size() > 0 && $urandom_range(9) < 8) begin
                pick = $urandom_range(pool_prio.size() - 1);
                p = pool_prio[pick];
                k = pool_key[pick];
                if ($urandom_range(9) == 0) k = k ^ KW'(1);
            end
        end else begin
            case (roll % 4)
                0: op = OP_PEEK;
                1: op = OP_LIST_ALL;
                2: op = OP_LIST_EQ;
                default: op = OP_LIST_LE;
            endcase
            if (pool_prio.size() > 0 && $urandom_range(9) < 6)
                p = pool_prio[$urandom_range(pool_prio.size() - 1)];
        end
        send_word(op, p, k, may_idle);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_opcode       <= OP_PEEK;
        i_priority_req <= '0;
        i_entry_key    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_PEEK, 8'd0, 32'h0, 1'b1);
        send_word(OP_DELETE, 8'd9, 32'h1, 1'b1);
        send_word(OP_LIST_ALL, 8'd0, 32'h0, 1'b1);
        send_word(OP_LIST_EQ, 8'd0, 32'h0, 1'b1);
        send_word(OP_LIST_LE, 8'd255, 32'hffff_ffff, 1'b1);
        send_word(OP_INSERT, 8'd5, 32'h1234_5678, 1'b1);
        send_word(OP_INSERT, 8'd0, 32'h0, 1'b1);
        send_word(OP_INSERT, 8'd255, 32'hffff_ffff, 1'b1);
        send_word(OP_INSERT, 8'd5, 32'ha5a5_a5a5, 1'b1);
        send_word(OP_INSERT, 8'd5, 32'h1234_5678, 1'b1);
        send_word(OP_LIST_ALL, 8'd0, 32'h0, 1'b1);
        send_word(OP_LIST_EQ, 8'd5, 32'h0, 1'b1);
        send_word(OP_LIST_LE, 8'd4, 32'h0, 1'b1);
        send_word(OP_LIST_LE, 8'd255, 32'h0, 1'b1);
        send_word(OP_LIST_EQ, 8'd7, 32'h0, 1'b1);
        send_word(OP_DELETE, 8'd5, 32'h1234_5679, 1'b1);
        send_word(OP_DELETE, 8'd5, 32'h1234_5678, 1'b1);
        send_word(OP_PEEK, 8'd0, 32'h0, 1'b1);
        send_word(OP_UNUSED, 8'd255, 32'hffff_ffff, 1'b1);
        send_word(OP_DELETE, 8'd0, 32'h0, 1'b1);
        send_word(OP_DELETE, 8'd255, 32'hffff_ffff, 1'b1);
        send_word(OP_CLEAR, 8'd0, 32'h0, 1'b1);
        send_word(OP_PEEK, 8'd0, 32'h0, 1'b1);
        send_word(OP_INSERT, 8'd128, 32'h5a5a_5a5a, 1'b1);
        directed_words = counted_words;

        phase = 0;
        while (counted_words < directed_words + RANDOM_WORDS) begin
            repeat (PHASE_WORDS) random_word(phase % 3, phase != 4);
            phase++;
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d command words (%0d directed), checked %0d result words.",
                 counted_words, directed_words, checked_words);
        $display("Random part ran %0d fill, mixed and drain phases on a %0d-entry queue.",
                 phase, CAPACITY);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_store.sv
rtl/core/spq_cmp.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_chk.sv
bench/spq_checker.sv
bench/testbench.sv
